[rtl/core/stt_pkg.sv]
`default_nettype none
package stt_pkg;

	// table geometry
	localparam int INDEX_BITS = 16;
	localparam int SLOT_COUNT = 1 << INDEX_BITS;

	// register reset
	localparam logic [14:0] MATE_BOUND_RESET = 15'd29000;

	// operation codes
	localparam logic OP_PROBE = 1'b0;
	localparam logic OP_STORE = 1'b1;

	// bound kinds
	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_LOWER = 2'd1;
	localparam logic [1:0] KIND_UPPER = 2'd2;

	// one request as it travels from front to back
	typedef struct packed {
		logic               func;
		logic [63:0]        key;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
		logic [1:0]         kind;
		logic [15:0]        move;
		logic [7:0]         ply;
	} stt_item_t;

	// one table slot
	typedef struct packed {
		logic               valid;
		logic [63:0]        key;
		logic [15:0]        move;
		logic [1:0]         kind;
		logic signed [7:0]  depth;
		logic signed [15:0] score;
	} stt_slot_t;

	// mate score shift by ply, toward the root on store, away from it on probe
	function automatic logic signed [15:0] stt_mate_adjust(
		input logic signed [15:0] s,
		input logic [7:0]         ply,
		input logic               toward_root,
		input logic [14:0]        bound
	);
		logic signed [17:0] s18;
		logic signed [17:0] ply18;
		logic signed [17:0] sum;
		logic [16:0]        mag;
		logic               pos;
		logic               add;
		s18   = 18'(s);
		ply18 = signed'({10'b0, ply});
		mag   = s[15] ? 17'(-s18) : 17'(s18);
		pos   = !s[15] && (s != 16'sd0);
		add   = (pos == toward_root);
		sum   = s18;
		if (mag >= {2'b00, bound}) begin
			sum = add ? (s18 + ply18) : (s18 - ply18);
		end
		if (sum > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (sum < -18'sd32768) begin
			return 16'sh8000;
		end
		return sum[15:0];
	endfunction

endpackage
`default_nettype wire

[rtl/core/stt_if.sv]
`default_nettype none
// request channel
interface stt_in_if;
	import stt_pkg::*;
	logic               valid;
	logic               ready;
	logic               func;
	logic [63:0]        position_key;
	logic signed [7:0]  search_depth;
	logic signed [15:0] score_in;
	logic signed [15:0] alpha_bound;
	logic signed [15:0] beta_bound;
	logic [1:0]         bound_kind;
	logic [15:0]        move_in;
	logic [7:0]         ply_now;
	modport source (output valid, func, position_key, search_depth, score_in, alpha_bound,
		beta_bound, bound_kind, move_in, ply_now, input ready);
	modport sink (input valid, func, position_key, search_depth, score_in, alpha_bound,
		beta_bound, bound_kind, move_in, ply_now, output ready);
endinterface

// result channel
interface stt_out_if;
	logic               valid;
	logic               ready;
	logic               key_found;
	logic               cutoff;
	logic signed [15:0] score_out;
	logic [15:0]        move_out;
	logic [31:0]        hit_count;
	logic [31:0]        store_count;
	modport source (output valid, key_found, cutoff, score_out, move_out, hit_count,
		store_count, input ready);
	modport sink (input valid, key_found, cutoff, score_out, move_out, hit_count,
		store_count, output ready);
endinterface

// register write channel
interface stt_cfg_if;
	logic        valid;
	logic        ready;
	logic [14:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/core/stt_front.sv]
`default_nettype none
module stt_front (
	stt_in_if.sink           in_ch,
	input  wire logic        clearing,
	input  wire logic        q_full,
	input  wire logic [14:0] mate_bound,
	output stt_pkg::stt_item_t push_item,
	output logic             push
);
	import stt_pkg::*;

	// take items only when the queue has room and the table is cleared
	assign in_ch.ready = !clearing && !q_full;
	assign push        = in_ch.valid && in_ch.ready;

	// pass the request on and pre-adjust a store score toward the root
	always_comb begin
		push_item.func  = in_ch.func;
		push_item.key   = in_ch.position_key;
		push_item.depth = in_ch.search_depth;
		push_item.score = in_ch.score_in;
		push_item.alpha = in_ch.alpha_bound;
		push_item.beta  = in_ch.beta_bound;
		push_item.kind  = in_ch.bound_kind;
		push_item.move  = in_ch.move_in;
		push_item.ply   = in_ch.ply_now;
		if (in_ch.func == OP_STORE) begin
			push_item.score = stt_mate_adjust(in_ch.score_in, in_ch.ply_now, 1'b1, mate_bound);
		end
	end
endmodule
`default_nettype wire

[rtl/core/stt_queue.sv]
`default_nettype none
module stt_queue (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire stt_pkg::stt_item_t push_item,
	input  wire logic      pop,
	output logic           full,
	output logic           head_valid,
	output stt_pkg::stt_item_t head_item
);
	import stt_pkg::*;

	stt_item_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end
endmodule
`default_nettype wire

[rtl/core/stt_back.sv]
`default_nettype none
module stt_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire stt_pkg::stt_item_t head_item,
	input  wire logic [14:0] mate_bound,
	output logic             pop,
	output logic             clearing,
	stt_out_if.source        out_ch
);
	import stt_pkg::*;

	localparam logic [1:0] B_CLEAR = 2'd0;
	localparam logic [1:0] B_IDLE  = 2'd1;
	localparam logic [1:0] B_EVAL  = 2'd2;
	localparam logic [1:0] B_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [INDEX_BITS-1:0] clr_q;
	stt_item_t             cur_q;
	stt_slot_t             mem [SLOT_COUNT];
	stt_slot_t             rd_q;
	stt_slot_t             wdata;
	logic [INDEX_BITS-1:0] addr;
	logic                  we;

	logic                  ev_found_q;
	logic                  ev_deep_q;
	logic [1:0]            ev_kind_q;
	logic signed [15:0]    ev_score_q;
	logic [15:0]           ev_move_q;

	logic [31:0]           hits_q;
	logic [31:0]           stores_q;
	logic                  out_valid_q;
	logic                  out_found_q;
	logic                  out_cut_q;
	logic signed [15:0]    out_score_q;
	logic [15:0]           out_move_q;

	logic                  out_free;
	logic signed [15:0]    t_score;
	logic                  t_cut;

	assign clearing = (state_q == B_CLEAR);
	assign pop      = (state_q == B_IDLE) && head_valid;
	assign out_free = !out_valid_q || out_ch.ready;

	// memory port control
	always_comb begin
		wdata.valid = 1'b1;
		wdata.key   = head_item.key;
		wdata.move  = head_item.move;
		wdata.kind  = head_item.kind;
		wdata.depth = head_item.depth;
		wdata.score = head_item.score;
		addr        = head_item.key[INDEX_BITS-1:0];
		we          = pop && (head_item.func == OP_STORE);
		if (clearing) begin
			wdata.valid = 1'b0;
			addr        = clr_q;
			we          = 1'b1;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	// probe result from evaluated slot
	always_comb begin
		t_score = stt_mate_adjust(ev_score_q, cur_q.ply, 1'b0, mate_bound);
		t_cut   = 1'b0;
		if (ev_found_q && ev_deep_q) begin
			unique case (ev_kind_q)
				KIND_EXACT: t_cut = 1'b1;
				KIND_LOWER: t_cut = (t_score >= cur_q.beta);
				KIND_UPPER: t_cut = (t_score <= cur_q.alpha);
				default:    t_cut = 1'b0;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_q       <= '0;
			hits_q      <= '0;
			stores_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: load on completion, drop once taken
			if (state_q == B_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + INDEX_BITS'(1);
					if (&clr_q) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (head_valid) begin
						state_q <= (head_item.func == OP_STORE) ? B_DONE : B_EVAL;
					end
				end
				B_EVAL: begin
					state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free) begin
						state_q <= B_IDLE;
						if (cur_q.func == OP_STORE) begin
							stores_q <= stores_q + 32'd1;
						end else if (ev_found_q) begin
							hits_q <= hits_q + 32'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// item and slot evaluation
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head_item;
		end
		if (state_q == B_EVAL) begin
			ev_found_q <= rd_q.valid && (rd_q.key == cur_q.key);
			ev_deep_q  <= (rd_q.depth >= cur_q.depth);
			ev_kind_q  <= rd_q.kind;
			ev_score_q <= rd_q.score;
			ev_move_q  <= rd_q.move;
		end
		if (state_q == B_DONE && out_free) begin
			if (cur_q.func == OP_STORE) begin
				out_found_q <= 1'b0;
				out_cut_q   <= 1'b0;
				out_score_q <= '0;
				out_move_q  <= '0;
			end else begin
				out_found_q <= ev_found_q;
				out_cut_q   <= t_cut;
				out_score_q <= t_cut ? t_score : 16'sd0;
				out_move_q  <= ev_found_q ? ev_move_q : 16'd0;
			end
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.key_found   = out_found_q;
	assign out_ch.cutoff      = out_cut_q;
	assign out_ch.score_out   = out_score_q;
	assign out_ch.move_out    = out_move_q;
	assign out_ch.hit_count   = hits_q;
	assign out_ch.store_count = stores_q;
endmodule
`default_nettype wire

[rtl/core/search_transposition_table_core.sv]
`default_nettype none
// channel  | dir | handshake     | carries
// in_ch    | in  | valid/ready   | func, key, depth, score, window, kind, move, ply
// out_ch   | out | valid/ready   | key_found, cutoff, score, move, hit and store counts
// cfg_ch   | in  | valid/ready   | mate_bound
//
// a store passes the back sequencer as slot write then result, a probe as slot read,
// evaluate, result; the single table port and the sequencer set this order
// after reset the table runs a clearing pass over all 65536 slots, one slot per cycle,
// with in_ch.ready low; cfg writes are taken at any time
// a two-item queue lets the front accept items while the back works or out_ch stalls
module search_transposition_table_core (
	input  wire logic clk,
	input  wire logic arst_n,
	stt_in_if.sink    in_ch,
	stt_out_if.source out_ch,
	stt_cfg_if.sink   cfg_ch
);
	import stt_pkg::*;

	logic [14:0] mate_bound_q;
	logic        clearing;
	logic        q_full;
	logic        push;
	logic        pop;
	logic        head_valid;
	stt_item_t   push_item;
	stt_item_t   head_item;

	// mate bound register
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mate_bound_q <= MATE_BOUND_RESET;
		end else if (cfg_ch.valid) begin
			mate_bound_q <= cfg_ch.data;
		end
	end

	stt_front u_front (
		.in_ch      (in_ch),
		.clearing   (clearing),
		.q_full     (q_full),
		.mate_bound (mate_bound_q),
		.push_item  (push_item),
		.push       (push)
	);

	stt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	stt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.mate_bound (mate_bound_q),
		.pop        (pop),
		.clearing   (clearing),
		.out_ch     (out_ch)
	);
endmodule
`default_nettype wire

[rtl/core/stt_checker.sv]
`default_nettype none
module stt_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        key_found,
	input wire logic        cutoff,
	input wire logic [15:0] score_out,
	input wire logic [15:0] move_out,
	input wire logic [31:0] hit_count,
	input wire logic [31:0] store_count
);
	// no items taken while in reset
	a_no_accept_in_reset: assert property (@(posedge clk) !arst_n |-> !in_ready)
		else $error("in_ready high during reset");

	// a cutoff needs a key match
	a_cut_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cutoff |-> key_found)
		else $error("cutoff without key match");

	// a miss or a store reports no move and no score
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !key_found |-> score_out == 16'd0 && move_out == 16'd0)
		else $error("miss result carries data");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_found) && $stable(cutoff)
		&& $stable(score_out) && $stable(move_out) && $stable(hit_count)
		&& $stable(store_count))
		else $error("stalled result changed");
endmodule

bind search_transposition_table_core stt_checker u_stt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.key_found   (out_ch.key_found),
	.cutoff      (out_ch.cutoff),
	.score_out   (out_ch.score_out),
	.move_out    (out_ch.move_out),
	.hit_count   (out_ch.hit_count),
	.store_count (out_ch.store_count)
);
`default_nettype wire
